[design/bqeq_pkg.sv]
// ----------------------------------------------------------------------------
// bqeq_pkg
// Shared types and constants of the stereo biquad cascade equaliser: payload
// structs, operation and coefficient codes, datapath widths.
// ----------------------------------------------------------------------------
`default_nettype none

package bqeq_pkg;

   // defaults for the top-level parameters
   localparam int STAGES_DEFAULT          = 7;
   localparam int COEFF_FRAC_BITS_DEFAULT = 27;

   // fixed field widths
   localparam int SAMPLE_BITS    = 24;
   localparam int COEFF_BITS     = 32;
   localparam int HIST_BITS      = 32;
   localparam int PROD_BITS      = COEFF_BITS + HIST_BITS;
   // five exact products plus sign growth
   localparam int ACC_BITS       = PROD_BITS + 3;
   localparam int STAGE_SEL_BITS = 3;
   localparam int NUM_COEFS      = 5;
   localparam int NUM_HIST       = 4;
   localparam int NUM_LANES      = 2;

   // history slots of one lane
   localparam int H_X1 = 0;
   localparam int H_X2 = 1;
   localparam int H_Y1 = 2;
   localparam int H_Y2 = 3;

   // lanes
   localparam int LANE_LEFT  = 0;
   localparam int LANE_RIGHT = 1;

   // register file
   localparam int   CSR_ADDR_BITS  = 3;
   localparam int   CSR_DATA_BITS  = 32;
   localparam logic CSR_MONO_INDEX = 1'b0;

   typedef enum logic [1:0] {
      OP_SAMPLE      = 2'd0,
      OP_COEFF_WRITE = 2'd1,
      OP_CLEAR       = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      COEF_B0 = 3'd0,
      COEF_B1 = 3'd1,
      COEF_B2 = 3'd2,
      COEF_A1 = 3'd3,
      COEF_A2 = 3'd4
   } coef_sel_type;

   typedef struct packed {
      op_type                          operation;
      logic signed [SAMPLE_BITS-1:0]   left_sample;
      logic signed [SAMPLE_BITS-1:0]   right_sample;
      logic [STAGE_SEL_BITS-1:0]       stage_select;
      coef_sel_type                    coeff_select;
      logic signed [COEFF_BITS-1:0]    coeff_value;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_out;
      logic signed [SAMPLE_BITS-1:0] right_out;
   } rsp_type;

   // broadcast command from the sequencer to every cell
   typedef struct packed {
      logic                          coeff_write;
      logic                          clear;
      logic [STAGE_SEL_BITS-1:0]     stage_select;
      coef_sel_type                  coeff_select;
      logic signed [COEFF_BITS-1:0]  coeff_value;
   } cell_cmd_type;

   // sample pair handed from one cell to the next
   typedef struct packed {
      logic                         valid;
      logic signed [HIST_BITS-1:0]  left_value;
      logic signed [HIST_BITS-1:0]  right_value;
   } link_type;

endpackage

`default_nettype wire

[design/bqeq_cell.sv]
// ----------------------------------------------------------------------------
// bqeq_cell
// One biquad section: holds its five coefficients and the left and right
// histories, runs one multiplier per lane through the five taps in turn and
// hands the rounded, saturated output to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module bqeq_cell
   import bqeq_pkg::*;
#(
   parameter int CELL_INDEX      = 0,
   parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cell_cmd_type cmd,
   input  wire link_type     link_in,
   output link_type          link_out
);

   localparam logic signed [COEFF_BITS-1:0] COEF_ONE =
      COEFF_BITS'(1) << COEFF_FRAC_BITS;
   localparam logic signed [ACC_BITS-1:0] ROUND_BIAS =
      ACC_BITS'(1) << (COEFF_FRAC_BITS - 1);
   localparam logic signed [ACC_BITS-1:0] Y_MAX =
      ACC_BITS'({1'b0, {(HIST_BITS-1){1'b1}}});
   localparam logic signed [ACC_BITS-1:0] Y_MIN = -Y_MAX - ACC_BITS'(1);

   logic signed [COEFF_BITS-1:0] coef_ff [NUM_COEFS];
   logic signed [HIST_BITS-1:0]  hist_ff [NUM_LANES][NUM_HIST];
   logic signed [HIST_BITS-1:0]  x_ff    [NUM_LANES];
   logic signed [HIST_BITS-1:0]  x_in    [NUM_LANES];
   logic signed [HIST_BITS-1:0]  oper    [NUM_LANES];
   logic signed [PROD_BITS-1:0]  prod_ff [NUM_LANES];
   logic signed [PROD_BITS-1:0]  prod_in [NUM_LANES];
   logic signed [ACC_BITS-1:0]   acc_ff  [NUM_LANES];
   logic signed [ACC_BITS-1:0]   shifted [NUM_LANES];
   logic signed [HIST_BITS-1:0]  y_in    [NUM_LANES];
   logic signed [HIST_BITS-1:0]  y_ff    [NUM_LANES];
   logic signed [COEFF_BITS-1:0] coef_sel;
   coef_sel_type                 step_ff;
   coef_sel_type                 step_in;
   logic                         busy_ff;
   logic                         prod_valid_ff;
   logic                         prod_last_ff;
   logic                         prod_neg_ff;
   logic                         fin_ff;
   logic                         out_valid_ff;
   logic                         stage_hit;

   assign stage_hit = (int'(cmd.stage_select) == CELL_INDEX);

   assign x_in[LANE_LEFT]  = link_in.left_value;
   assign x_in[LANE_RIGHT] = link_in.right_value;

   // operand selection for the current tap
   always_comb begin
      coef_sel = coef_ff[COEF_B0];
      step_in  = COEF_B0;
      for (int l = 0; l < NUM_LANES; l++) begin
         oper[l] = x_ff[l];
      end
      unique case (step_ff)
         COEF_B0: begin
            coef_sel = coef_ff[COEF_B0];
            step_in  = COEF_B1;
            for (int l = 0; l < NUM_LANES; l++) oper[l] = x_ff[l];
         end
         COEF_B1: begin
            coef_sel = coef_ff[COEF_B1];
            step_in  = COEF_B2;
            for (int l = 0; l < NUM_LANES; l++) oper[l] = hist_ff[l][H_X1];
         end
         COEF_B2: begin
            coef_sel = coef_ff[COEF_B2];
            step_in  = COEF_A1;
            for (int l = 0; l < NUM_LANES; l++) oper[l] = hist_ff[l][H_X2];
         end
         COEF_A1: begin
            coef_sel = coef_ff[COEF_A1];
            step_in  = COEF_A2;
            for (int l = 0; l < NUM_LANES; l++) oper[l] = hist_ff[l][H_Y1];
         end
         COEF_A2: begin
            coef_sel = coef_ff[COEF_A2];
            step_in  = COEF_B0;
            for (int l = 0; l < NUM_LANES; l++) oper[l] = hist_ff[l][H_Y2];
         end
         default: begin
            coef_sel = coef_ff[COEF_B0];
            step_in  = COEF_B0;
         end
      endcase
   end

   // one multiplier per lane, rounding shift and saturation of the sum
   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         prod_in[l] = PROD_BITS'(coef_sel) * PROD_BITS'(oper[l]);
         shifted[l] = acc_ff[l] >>> COEFF_FRAC_BITS;
         if (shifted[l] > Y_MAX) begin
            y_in[l] = HIST_BITS'(Y_MAX);
         end else if (shifted[l] < Y_MIN) begin
            y_in[l] = HIST_BITS'(Y_MIN);
         end else begin
            y_in[l] = HIST_BITS'(shifted[l]);
         end
      end
   end

   // control, coefficients and histories
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         prod_valid_ff <= 1'b0;
         prod_last_ff  <= 1'b0;
         prod_neg_ff   <= 1'b0;
         fin_ff        <= 1'b0;
         out_valid_ff  <= 1'b0;
         step_ff       <= COEF_B0;
         for (int c = 0; c < NUM_COEFS; c++) begin
            coef_ff[c] <= '0;
         end
         coef_ff[COEF_B0] <= COEF_ONE;
         for (int l = 0; l < NUM_LANES; l++) begin
            for (int h = 0; h < NUM_HIST; h++) begin
               hist_ff[l][h] <= '0;
            end
         end
      end else begin
         out_valid_ff <= fin_ff;

         // coefficient load addressed to this section
         if (cmd.coeff_write && stage_hit && (cmd.coeff_select <= COEF_A2)) begin
            coef_ff[cmd.coeff_select] <= cmd.coeff_value;
         end

         // history clear or update after a finished sample
         if (cmd.clear) begin
            for (int l = 0; l < NUM_LANES; l++) begin
               for (int h = 0; h < NUM_HIST; h++) begin
                  hist_ff[l][h] <= '0;
               end
            end
         end else if (fin_ff) begin
            for (int l = 0; l < NUM_LANES; l++) begin
               hist_ff[l][H_X2] <= hist_ff[l][H_X1];
               hist_ff[l][H_X1] <= x_ff[l];
               hist_ff[l][H_Y2] <= hist_ff[l][H_Y1];
               hist_ff[l][H_Y1] <= y_in[l];
            end
         end

         // tap sequencing
         if (link_in.valid) begin
            busy_ff <= 1'b1;
            step_ff <= COEF_B0;
         end else if (busy_ff) begin
            step_ff <= step_in;
            if (step_ff == COEF_A2) begin
               busy_ff <= 1'b0;
            end
         end
         prod_valid_ff <= busy_ff;
         prod_last_ff  <= busy_ff && (step_ff == COEF_A2);
         prod_neg_ff   <= (step_ff == COEF_A1) || (step_ff == COEF_A2);
         fin_ff        <= prod_valid_ff && prod_last_ff;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      for (int l = 0; l < NUM_LANES; l++) begin
         prod_ff[l] <= prod_in[l];
         if (link_in.valid) begin
            x_ff[l]   <= x_in[l];
            acc_ff[l] <= ROUND_BIAS;
         end else if (prod_valid_ff) begin
            if (prod_neg_ff) begin
               acc_ff[l] <= acc_ff[l] - ACC_BITS'(prod_ff[l]);
            end else begin
               acc_ff[l] <= acc_ff[l] + ACC_BITS'(prod_ff[l]);
            end
         end
         if (fin_ff) begin
            y_ff[l] <= y_in[l];
         end
      end
   end

   assign link_out.valid       = out_valid_ff;
   assign link_out.left_value  = y_ff[LANE_LEFT];
   assign link_out.right_value = y_ff[LANE_RIGHT];

endmodule

`default_nettype wire

[design/stereo_biquad_cascade_eq_unit.sv]
// ----------------------------------------------------------------------------
// stereo_biquad_cascade_eq_unit
// Stereo equaliser: a chain of direct-form-1 biquad cells sharing coefficients
// between left and right, with an APB-style register for mono mode.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (valid/ready) carries one transaction: a sample pair, a
//   coefficient write (stage, tap, Q value) or a clear of all histories.
//   rsp channel (valid/ready) returns one filtered pair per sample
//   transaction; coefficient writes and clears return nothing.
//   A sample pair walks the cell chain; each cell steps through operand
//   capture, five multiplier passes per lane, a final accumulate and one
//   round and saturate. The next sample is taken once the result has left
//   the chain; coefficient writes and clears do not leave the idle state.
//   The finished pair waits in a holding register while rsp stalls; a new
//   transaction is accepted as soon as it has moved into the output register.
//   Reset (synchronous) loads pass-through coefficients (b0 = 1.0), zeroes
//   all histories and clears mono mode; the block is ready in the next cycle.
//   Register 0 at byte address 0: bit 0 mono mode (left feeds both lanes).
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_biquad_cascade_eq_unit
   import bqeq_pkg::*;
#(
   parameter int STAGES          = STAGES_DEFAULT,
   parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire req_type                  req_payload,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output rsp_type                       rsp_payload,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0]      prdata,
   output logic                          pready
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   localparam logic signed [HIST_BITS-1:0] S_MAX =
      HIST_BITS'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
   localparam logic signed [HIST_BITS-1:0] S_MIN = -S_MAX - HIST_BITS'(1);

   state_type                    state_ff;
   logic                         mono_ff;
   cell_cmd_type                 cmd_ff;
   link_type                     start_ff;
   link_type                     link [STAGES+1];
   rsp_type                      hold_ff;
   rsp_type                      hold_in;
   rsp_type                      rsp_ff;
   logic                         rsp_valid_ff;
   logic                         req_accept;
   logic                         csr_write;
   logic signed [HIST_BITS-1:0]  left_in;

   assign pready     = 1'b1;
   assign req_ready  = (state_ff == ST_IDLE) && !reset;
   assign req_accept = req_valid && req_ready;
   assign csr_write  = psel && penable && pwrite && pready;
   assign left_in    = HIST_BITS'(req_payload.left_sample);

   // register read
   assign prdata = (paddr[CSR_ADDR_BITS-1] == CSR_MONO_INDEX) ?
                   CSR_DATA_BITS'(mono_ff) : '0;

   // final saturation to sample width
   always_comb begin
      if (link[STAGES].left_value > S_MAX) begin
         hold_in.left_out = SAMPLE_BITS'(S_MAX);
      end else if (link[STAGES].left_value < S_MIN) begin
         hold_in.left_out = SAMPLE_BITS'(S_MIN);
      end else begin
         hold_in.left_out = SAMPLE_BITS'(link[STAGES].left_value);
      end
      if (link[STAGES].right_value > S_MAX) begin
         hold_in.right_out = SAMPLE_BITS'(S_MAX);
      end else if (link[STAGES].right_value < S_MIN) begin
         hold_in.right_out = SAMPLE_BITS'(S_MIN);
      end else begin
         hold_in.right_out = SAMPLE_BITS'(link[STAGES].right_value);
      end
   end

   // sequencer: dispatch, wait for the chain, hand over the result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mono_ff      <= 1'b0;
         cmd_ff       <= '0;
         start_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cmd_ff.coeff_write <= 1'b0;
         cmd_ff.clear       <= 1'b0;
         start_ff.valid     <= 1'b0;

         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_write && (paddr[CSR_ADDR_BITS-1] == CSR_MONO_INDEX)) begin
            mono_ff <= pwdata[0];
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  unique case (req_payload.operation)
                     OP_SAMPLE: begin
                        start_ff.valid       <= 1'b1;
                        start_ff.left_value  <= left_in;
                        start_ff.right_value <= mono_ff ? left_in :
                                                HIST_BITS'(req_payload.right_sample);
                        state_ff             <= ST_RUN;
                     end
                     OP_COEFF_WRITE: begin
                        cmd_ff.coeff_write  <= 1'b1;
                        cmd_ff.stage_select <= req_payload.stage_select;
                        cmd_ff.coeff_select <= req_payload.coeff_select;
                        cmd_ff.coeff_value  <= req_payload.coeff_value;
                     end
                     OP_CLEAR: begin
                        cmd_ff.clear <= 1'b1;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_RUN: begin
               if (link[STAGES].valid) begin
                  hold_ff  <= hold_in;
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff       <= hold_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // chain of biquad cells
   assign link[0] = start_ff;

   for (genvar s = 0; s < STAGES; s++) begin : g_cell
      bqeq_cell #(
         .CELL_INDEX      (s),
         .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd_ff),
         .link_in  (link[s]),
         .link_out (link[s+1])
      );
   end

endmodule

`default_nettype wire
